FILE: hdl/pwm_tdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM tone divider package
// Field widths, register map, fixed limits and shared types of the tone
// divider and top calculator.
// ----------------------------------------------------------------------------
package pwm_tdc_pkg;

   // field widths
   localparam int CLK_W   = 29;
   localparam int FREQ_W  = 16;
   localparam int DUTY_W  = 17;
   localparam int DIV_W   = 13;
   localparam int FIELD_W = 16;

   // fixed limits
   localparam logic [DUTY_W-1:0] DUTY_ONE  = 17'd65536;
   localparam logic [DIV_W-1:0]  DIV_MAX   = 13'd8191;
   localparam logic [CLK_W-1:0]  CLK_RESET = 29'd125000000;

   // register map: one register, index taken from paddr[2]
   localparam int           CSR_ADDR_W    = 3;
   localparam logic [0:0]   REG_SYS_CLOCK = 1'b0;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV1,
      ST_MUL1,
      ST_DIV2,
      ST_MUL2,
      ST_WRITE
   } state_type;

   // status of a serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

FILE: hdl/pwm_tone_divider_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM tone divider and top calculator
// Turns a tone frequency and duty into a clock divider, counter top and
// compare level, using a shared serial divider and serial multiplier.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents
//  --------+-----+-----------------------------------------------------------
//  req_    | in  | tone_freq_hz, duty_frac
//  rsp_    | out | clock_divider, counter_top, compare_level; flags in tuser
//  csr_    | in  | sys_clock_hz at byte address 0
//
//  A beat with a nonzero frequency not above the clock runs the bit-serial
//  divider (29 steps, run twice) and multiplier (17 steps, run twice) in turn
//  before its result loads; a stop or too-high beat goes straight from accept
//  to the write state. One beat is in work at a time and the next is taken in
//  the cycle after the result loads; a waiting result stalls only that hand-over.
//  Reset clears the sequencer and loads 125 MHz.
// ----------------------------------------------------------------------------
module pwm_tone_divider_calc
   import pwm_tdc_pkg::*;
#(
   parameter int TOP_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata: [15:0] tone_freq_hz, [32:16] duty_frac, [39:33] zero
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [39:0]            req_tdata,
   // rsp_tdata: [12:0] clock_divider, [28:13] counter_top,
   //            [44:29] compare_level, [47:45] zero
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [47:0]            rsp_tdata,
   // rsp_tuser: [0] timing_update, [1] freq_too_high
   output logic [1:0]             rsp_tuser,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   localparam int TW     = (TOP_BITS < CLK_W) ? TOP_BITS : CLK_W;
   localparam int AW     = (TW > DIV_W) ? TW : DIV_W;
   localparam int PW     = AW + DUTY_W;
   localparam int DVS_W  = (TOP_BITS + FREQ_W + 1 > CLK_W) ? TOP_BITS + FREQ_W + 1 : CLK_W;
   localparam logic [CLK_W-1:0] TOP_LIM = (TOP_BITS >= CLK_W) ? {CLK_W{1'b1}} :
                                          CLK_W'((64'd1 << TOP_BITS) - 64'd1);

   state_type         state_ff, state_in;
   logic [CLK_W-1:0]  clk_ff;
   logic [FREQ_W-1:0] freq_ff, freq_in;
   logic [DUTY_W-1:0] duty_ff, duty_in;
   logic [DIV_W-1:0]  pdiv_ff, pdiv_in;
   logic [FIELD_W-1:0] ptop_ff, ptop_in;
   logic [FIELD_W-1:0] plvl_ff, plvl_in;
   logic              pupd_ff, pupd_in;
   logic              phigh_ff, phigh_in;
   logic              rvalid_ff, rvalid_in;
   logic [DIV_W-1:0]  rdiv_ff, rdiv_in;
   logic [FIELD_W-1:0] rtop_ff, rtop_in;
   logic [FIELD_W-1:0] rlvl_ff, rlvl_in;
   logic              rupd_ff, rupd_in;
   logic              rhigh_ff, rhigh_in;

   logic [FREQ_W-1:0] req_freq;
   logic [DUTY_W-1:0] req_duty;
   logic [DUTY_W-1:0] duty_sat;
   logic              csr_wr;

   logic               div_start;
   logic [DVS_W-1:0]   div_divisor;
   logic [CLK_W-1:0]   div_quot;
   unit_stat_type      div_stat;
   logic               mul_start;
   logic [AW-1:0]      mul_a;
   logic [DUTY_W-1:0]  mul_b;
   logic [PW-1:0]      mul_prod;
   unit_stat_type      mul_stat;

   logic [DIV_W-1:0]   div_calc;
   logic [CLK_W-1:0]   qm1;
   logic [CLK_W-1:0]   top_sat;
   logic [PW-1:0]      lvl_shift;

   assign req_freq = req_tdata[FREQ_W-1:0];
   assign req_duty = req_tdata[FREQ_W+DUTY_W-1:FREQ_W];
   assign duty_sat = (req_duty > DUTY_ONE) ? DUTY_ONE : req_duty;

   // configuration register
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == REG_SYS_CLOCK);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_SYS_CLOCK) ? 32'(clk_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_ff <= CLK_RESET;
      end else if (csr_wr) begin
         clk_ff <= csr_pwdata[CLK_W-1:0];
      end
   end

   // arithmetic units
   pwm_tdc_div #(
      .DW (DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (clk_ff),
      .divisor  (div_divisor),
      .quotient (div_quot),
      .stat     (div_stat)
   );

   pwm_tdc_mul #(
      .AW (AW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_prod),
      .stat    (mul_stat)
   );

   // divider from first quotient, top from second quotient, level from product
   assign div_calc  = (div_quot >= CLK_W'(DIV_MAX)) ? DIV_MAX :
                      DIV_W'(div_quot + CLK_W'(1));
   assign qm1       = (div_quot == '0) ? '0 : div_quot - CLK_W'(1);
   assign top_sat   = (qm1 > TOP_LIM) ? TOP_LIM : qm1;
   assign lvl_shift = mul_prod >> 16;

   // sequencer: next state, unit launches and result capture
   always_comb begin
      state_in    = state_ff;
      freq_in     = freq_ff;
      duty_in     = duty_ff;
      pdiv_in     = pdiv_ff;
      ptop_in     = ptop_ff;
      plvl_in     = plvl_ff;
      pupd_in     = pupd_ff;
      phigh_in    = phigh_ff;
      rvalid_in   = rvalid_ff;
      rdiv_in     = rdiv_ff;
      rtop_in     = rtop_ff;
      rlvl_in     = rlvl_ff;
      rupd_in     = rupd_ff;
      rhigh_in    = rhigh_ff;
      req_tready  = 1'b0;
      div_start   = 1'b0;
      div_divisor = (DVS_W'(req_freq) << TOP_BITS) + DVS_W'(req_freq);
      mul_start   = 1'b0;
      mul_a       = AW'(div_calc);
      mul_b       = DUTY_W'(freq_ff);

      // drop the output beat once taken
      if (rvalid_ff && rsp_tready) begin
         rvalid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               freq_in  = req_freq;
               duty_in  = duty_sat;
               pdiv_in  = '0;
               ptop_in  = '0;
               plvl_in  = '0;
               pupd_in  = 1'b0;
               phigh_in = 1'b0;
               if (req_freq == '0) begin
                  state_in = ST_WRITE;
               end else if (CLK_W'(req_freq) > clk_ff) begin
                  phigh_in = 1'b1;
                  state_in = ST_WRITE;
               end else begin
                  pupd_in   = 1'b1;
                  div_start = 1'b1;
                  state_in  = ST_DIV1;
               end
            end
         end
         ST_DIV1: begin
            if (div_stat.done) begin
               pdiv_in   = div_calc;
               mul_start = 1'b1;
               state_in  = ST_MUL1;
            end
         end
         ST_MUL1: begin
            div_divisor = DVS_W'(mul_prod[CLK_W-1:0]);
            if (mul_stat.done) begin
               div_start = 1'b1;
               state_in  = ST_DIV2;
            end
         end
         ST_DIV2: begin
            mul_a = AW'(top_sat);
            mul_b = duty_ff;
            if (div_stat.done) begin
               ptop_in   = top_sat[FIELD_W-1:0];
               mul_start = 1'b1;
               state_in  = ST_MUL2;
            end
         end
         ST_MUL2: begin
            if (mul_stat.done) begin
               plvl_in  = lvl_shift[FIELD_W-1:0];
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            // hold until the output register is free
            if (!rvalid_ff || rsp_tready) begin
               rvalid_in = 1'b1;
               rdiv_in   = pdiv_ff;
               rtop_in   = ptop_ff;
               rlvl_in   = plvl_ff;
               rupd_in   = pupd_ff;
               rhigh_in  = phigh_ff;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
      end
      freq_ff  <= freq_in;
      duty_ff  <= duty_in;
      pdiv_ff  <= pdiv_in;
      ptop_ff  <= ptop_in;
      plvl_ff  <= plvl_in;
      pupd_ff  <= pupd_in;
      phigh_ff <= phigh_in;
      rdiv_ff  <= rdiv_in;
      rtop_ff  <= rtop_in;
      rlvl_ff  <= rlvl_in;
      rupd_ff  <= rupd_in;
      rhigh_ff <= rhigh_in;
   end

   // output beat
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {3'b000, rlvl_ff, rtop_ff, rdiv_ff};
   assign rsp_tuser  = {rhigh_ff, rupd_ff};

   // checks
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("timing update and too-high flag both set");

   a_stop_clears_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[44:0] == '0))
      else $error("stop result carries nonzero fields");

   a_divider_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[12:0] != '0))
      else $error("timing update with zero divider");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a beat is in work");

   a_units_not_both_busy: assert property (@(posedge clock) disable iff (reset)
      !(div_stat.busy && mul_stat.busy))
      else $error("divider and multiplier running together");

endmodule

FILE: hdl/pwm_tdc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial restoring divider
// Produces one quotient bit per cycle for a CLK_W-bit dividend over a
// DW-bit divisor; the partial remainder never exceeds CLK_W bits.
// ----------------------------------------------------------------------------
module pwm_tdc_div
   import pwm_tdc_pkg::*;
#(
   parameter int DW = 33
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [CLK_W-1:0]    dividend,
   input  logic [DW-1:0]       divisor,
   output logic [CLK_W-1:0]    quotient,
   output unit_stat_type       stat
);

   localparam int EW    = (DW > CLK_W + 1) ? DW : CLK_W + 1;
   localparam int CNT_W = $clog2(CLK_W + 1);

   logic [EW-1:0]    dvs_ext;
   logic [CLK_W:0]   dvs_ff, dvs_in;
   logic             big_ff, big_in;
   logic [CLK_W-1:0] rem_ff, rem_in;
   logic [CLK_W-1:0] dq_ff, dq_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CLK_W:0]   trial;
   logic [CLK_W:0]   diff;
   logic             take;

   assign dvs_ext = EW'(divisor);
   assign trial   = {rem_ff, dq_ff[CLK_W-1]};
   assign diff    = trial - dvs_ff;
   assign take    = !big_ff && (trial >= dvs_ff);

   // load operands on start, then shift one quotient bit in per cycle
   always_comb begin
      dvs_in  = dvs_ff;
      big_in  = big_ff;
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvs_in  = dvs_ext[CLK_W:0];
         big_in  = (dvs_ext >> (CLK_W + 1)) != '0;
         rem_in  = '0;
         dq_in   = dividend;
         cnt_in  = CNT_W'(CLK_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = take ? diff[CLK_W-1:0] : trial[CLK_W-1:0];
         dq_in  = {dq_ff[CLK_W-2:0], take};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvs_ff <= dvs_in;
      big_ff <= big_in;
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
   end

   assign quotient  = dq_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

FILE: hdl/pwm_tdc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial shift-add multiplier
// Walks the DUTY_W-bit multiplier one bit per cycle, LSB first; the
// accumulator shifts right so the adder stays AW+1 bits wide.
// ----------------------------------------------------------------------------
module pwm_tdc_mul
   import pwm_tdc_pkg::*;
#(
   parameter int AW = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [AW-1:0]         op_a,
   input  logic [DUTY_W-1:0]     op_b,
   output logic [AW+DUTY_W-1:0]  product,
   output unit_stat_type         stat
);

   localparam int CNT_W = $clog2(DUTY_W + 1);

   logic [AW-1:0]     a_ff, a_in;
   logic [DUTY_W-1:0] b_ff, b_in;
   logic [AW-1:0]     hi_ff, hi_in;
   logic [DUTY_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [AW:0]       sum;

   assign sum = {1'b0, hi_ff} + (b_ff[0] ? {1'b0, a_ff} : '0);

   // add the partial product, retire one low product bit per cycle
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         hi_in   = '0;
         lo_in   = '0;
         cnt_in  = CNT_W'(DUTY_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum[AW:1];
         lo_in  = {sum[0], lo_ff[DUTY_W-1:1]};
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff  <= a_in;
      b_ff  <= b_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign product   = {hi_ff, lo_ff};
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

FILE: sim/tb_pwm_tone_divider_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM tone divider and top calculator testbench
// Drives tone requests through the stream input under several system clock
// settings, predicts divider, top, level and flags for every beat, and
// compares each result beat field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_pwm_tone_divider_calc;
   import pwm_tdc_pkg::*;

   localparam int          TOP_BITS       = 16;
   localparam logic [63:0] TOP_MAX        = (64'd1 << TOP_BITS) - 64'd1;
   localparam int          RESULT_LATENCY = 97;
   localparam int          WATCHDOG_LIMIT = 5000;
   localparam int          PHASE_ITEMS    = 120;
   localparam int          NUM_PHASES     = 12;
   localparam logic [31:0] CLK_HIGH_HZ    = 32'd400000000;
   localparam logic [31:0] CLK_RESET_HZ   = 32'(CLK_RESET);
   localparam logic [CSR_ADDR_W-1:0] SYS_CLOCK_ADDR = {REG_SYS_CLOCK, 2'b00};

   typedef struct packed {
      logic [DIV_W-1:0]   clock_divider;
      logic [FIELD_W-1:0] counter_top;
      logic [FIELD_W-1:0] compare_level;
      logic               timing_update;
      logic               freq_too_high;
   } tone_timing_type;

   typedef struct packed {
      logic [31:0]        clk_word;
      logic [FREQ_W-1:0]  freq;
      logic [DUTY_W-1:0]  duty;
      logic               fixed_want;
      tone_timing_type    want;
   } tone_case_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_PATTERN,
      STALL_HEAVY,
      STALL_LIGHT
   } stall_mode_type;

   localparam tone_timing_type STOP_TIMING = '0;
   localparam tone_timing_type TOO_HIGH_TIMING = '{clock_divider: '0, counter_top: '0,
      compare_level: '0, timing_update: 1'b0, freq_too_high: 1'b1};
   localparam tone_timing_type UNIT_TIMING = '{clock_divider: 13'd1, counter_top: '0,
      compare_level: '0, timing_update: 1'b1, freq_too_high: 1'b0};

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [39:0]           req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [47:0]           rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   tone_timing_type       pending_timing[$];
   tone_case_type         tone_cases[$];
   logic [CLK_W-1:0]      sys_clock_shadow = CLK_RESET;
   tone_timing_type       rsp_got;
   tone_timing_type       rsp_want;
   int                    mismatches     = 0;
   int                    tones_sent     = 0;
   int                    results_seen   = 0;
   int                    timing_results = 0;
   int                    stop_results   = 0;
   int                    high_results   = 0;
   int                    clock_settings = 0;
   int                    burst_left     = 0;
   int                    idle_cycles    = 0;

   pwm_tone_divider_calc #(
      .TOP_BITS (TOP_BITS)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // Work out divider, top and compare level for one tone request
   function automatic tone_timing_type calc_tone_timing(input logic [FREQ_W-1:0] freq,
                                                        input logic [DUTY_W-1:0] duty,
                                                        input logic [CLK_W-1:0]  sys_clk);
      logic [63:0]     f, d, c, div, quot, top, level;
      tone_timing_type t;
      t = '0;
      f = 64'(freq);
      d = 64'(duty);
      c = 64'(sys_clk);
      // stop request wins over everything else
      if (f == 64'd0) begin
         return t;
      end
      // no divider can reach a tone above the clock
      if (f > c) begin
         t.freq_too_high = 1'b1;
         return t;
      end
      if (d > 64'(DUTY_ONE)) begin
         d = 64'(DUTY_ONE);
      end
      // smallest divider that keeps the top within range, clamped to the field
      div = c / ((TOP_MAX + 64'd2) * f) + 64'd1;
      if (div > 64'(DIV_MAX)) begin
         div = 64'(DIV_MAX);
      end
      quot = c / (div * f);
      top  = (quot == 64'd0) ? 64'd0 : quot - 64'd1;
      if (top > TOP_MAX) begin
         top = TOP_MAX;
      end
      level = (top * d) >> 16;
      t.clock_divider = div[DIV_W-1:0];
      t.counter_top   = top[FIELD_W-1:0];
      t.compare_level = level[FIELD_W-1:0];
      t.timing_update = 1'b1;
      return t;
   endfunction

   task automatic compare_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
         mismatches++;
      end
   endtask

   task automatic add_tone_case(input logic [31:0] clk_word, input logic [FREQ_W-1:0] freq,
                                input logic [DUTY_W-1:0] duty, input logic fixed_want,
                                input tone_timing_type want);
      tone_case_type row;
      row.clk_word   = clk_word;
      row.freq       = freq;
      row.duty       = duty;
      row.fixed_want = fixed_want;
      row.want       = want;
      tone_cases.push_back(row);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_read(input logic [CSR_ADDR_W-1:0] addr, output logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Write the clock register, track it, and read it back
   task automatic set_sys_clock(input logic [31:0] word);
      logic [31:0] readback;
      csr_write(SYS_CLOCK_ADDR, word);
      sys_clock_shadow = word[CLK_W-1:0];
      clock_settings++;
      @(posedge clock);
      csr_read(SYS_CLOCK_ADDR, readback);
      compare_field("sys_clock_hz readback", {{(32-CLK_W){1'b0}}, sys_clock_shadow}, readback);
      @(posedge clock);
   endtask

   // Offer one request beat; bursts of random length with random gaps between
   task automatic send_tone(input logic [FREQ_W-1:0] freq, input logic [DUTY_W-1:0] duty,
                            input tone_timing_type want);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 6);
      end
      burst_left--;
      req_tdata  <= {7'd0, duty, freq};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_timing.push_back(want);
      tones_sent++;
   endtask

   // Hold the sender until every outstanding result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_timing.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Receiver stalls: switch between styles after each random span
   initial begin : rsp_stall_pattern
      logic [15:0]    pat;
      stall_mode_type mode;
      int             span;
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(40, 240);
         pat  = 16'($urandom) | 16'h0001;
         for (int k = 0; k < span; k++) begin
            @(posedge clock);
            case (mode)
               STALL_NONE:    rsp_tready <= 1'b1;
               STALL_PATTERN: rsp_tready <= pat[k % 16];
               STALL_HEAVY:   rsp_tready <= ($urandom_range(0, 3) == 0);
               default:       rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Check each result beat against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_got = {rsp_tdata[12:0], rsp_tdata[28:13], rsp_tdata[44:29],
                    rsp_tuser[0], rsp_tuser[1]};
         if (pending_timing.size() == 0) begin
            $display("%0t ns: result beat expected none, got %h", $time, rsp_got);
            mismatches++;
         end else begin
            rsp_want = pending_timing.pop_front();
            compare_field("clock_divider", 32'(rsp_want.clock_divider),
                          32'(rsp_got.clock_divider));
            compare_field("counter_top", 32'(rsp_want.counter_top),
                          32'(rsp_got.counter_top));
            compare_field("compare_level", 32'(rsp_want.compare_level),
                          32'(rsp_got.compare_level));
            compare_field("timing_update", 32'(rsp_want.timing_update),
                          32'(rsp_got.timing_update));
            compare_field("freq_too_high", 32'(rsp_want.freq_too_high),
                          32'(rsp_got.freq_too_high));
         end
         results_seen++;
         if (rsp_got.timing_update) begin
            timing_results++;
         end else if (rsp_got.freq_too_high) begin
            high_results++;
         end else begin
            stop_results++;
         end
      end
   end

   // Count cycles in which no beat moves on any port
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : watchdog
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("%0t ns: no beat moved for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, pending_timing.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      tone_case_type     row;
      tone_timing_type   want;
      logic [31:0]       phase_word;
      logic [FREQ_W-1:0] freq;
      logic [DUTY_W-1:0] duty;

      // directed cases: stops, extremes, duty saturation, too-high, overflow
      add_tone_case(CLK_RESET_HZ, 16'd0, 17'd0, 1'b1, STOP_TIMING);
      add_tone_case(CLK_RESET_HZ, 16'd0, 17'h1FFFF, 1'b1, STOP_TIMING);
      add_tone_case(CLK_RESET_HZ, 16'd1, DUTY_ONE, 1'b0, STOP_TIMING);
      add_tone_case(CLK_RESET_HZ, 16'd1, 17'h1FFFF, 1'b0, STOP_TIMING);
      add_tone_case(CLK_RESET_HZ, 16'hFFFF, 17'd0, 1'b0, STOP_TIMING);
      add_tone_case(CLK_RESET_HZ, 16'hFFFF, 17'd65535, 1'b0, STOP_TIMING);
      add_tone_case(CLK_RESET_HZ, 16'hFFFF, 17'h10001, 1'b0, STOP_TIMING);
      add_tone_case(CLK_RESET_HZ, 16'd1907, 17'h0AAAA, 1'b0, STOP_TIMING);
      add_tone_case(32'd1, 16'd1, DUTY_ONE, 1'b1, UNIT_TIMING);
      add_tone_case(32'd1, 16'd2, DUTY_ONE, 1'b1, TOO_HIGH_TIMING);
      add_tone_case(32'd1, 16'hFFFF, 17'h1FFFF, 1'b1, TOO_HIGH_TIMING);
      add_tone_case(32'd0, 16'd1, 17'd32768, 1'b1, TOO_HIGH_TIMING);
      add_tone_case(32'd0, 16'd0, DUTY_ONE, 1'b1, STOP_TIMING);
      add_tone_case(32'd65534, 16'hFFFF, 17'd100, 1'b1, TOO_HIGH_TIMING);
      add_tone_case(32'd65534, 16'd65534, DUTY_ONE, 1'b1, UNIT_TIMING);
      add_tone_case(CLK_HIGH_HZ, 16'd1, DUTY_ONE, 1'b0, STOP_TIMING);
      add_tone_case(CLK_HIGH_HZ, 16'hFFFF, 17'h15555, 1'b0, STOP_TIMING);
      add_tone_case(32'hFFFF_FFFF, 16'd1, DUTY_ONE, 1'b0, STOP_TIMING);
      add_tone_case(32'hFFFF_FFFF, 16'd2, DUTY_ONE, 1'b0, STOP_TIMING);
      add_tone_case(32'hFFFF_FFFF, 16'hFFFF, 17'd1, 1'b0, STOP_TIMING);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table, changing the clock only while idle
      foreach (tone_cases[i]) begin
         row = tone_cases[i];
         if (row.clk_word[CLK_W-1:0] != sys_clock_shadow) begin
            drain_results();
            set_sys_clock(row.clk_word);
         end
         want = row.fixed_want ? row.want
                               : calc_tone_timing(row.freq, row.duty, sys_clock_shadow);
         send_tone(row.freq, row.duty, want);
      end
      drain_results();

      // random phases, each under its own clock setting
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0:       phase_word = {{(32-CLK_W){1'b0}}, CLK_RESET};
            1, 7:    phase_word = $urandom_range(1, CLK_HIGH_HZ);
            2, 9:    phase_word = $urandom_range(1, 70000);
            3:       phase_word = CLK_HIGH_HZ;
            4:       phase_word = 32'hFFFF_FFFF;
            5:       phase_word = $urandom;
            6:       phase_word = 32'd1;
            8:       phase_word = 32'd0;
            10:      phase_word = 32'h1FFF_FFFF;
            default: phase_word = $urandom_range(100000, 200000000);
         endcase
         set_sys_clock(phase_word);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // now and then let everything in flight come home mid-phase
            if (p % 4 == 1 && n == PHASE_ITEMS / 2) begin
               drain_results();
            end
            case ($urandom_range(0, 15))
               0:       freq = '0;
               1:       freq = FREQ_W'($urandom_range(1, 16));
               2:       freq = (sys_clock_shadow < CLK_W'(65537))
                               ? FREQ_W'(sys_clock_shadow + $urandom_range(0, 2) - 1)
                               : FREQ_W'($urandom_range(1, 4096));
               3:       freq = '1;
               default: freq = FREQ_W'($urandom);
            endcase
            case ($urandom_range(0, 7))
               0:       duty = '0;
               1:       duty = DUTY_ONE;
               2:       duty = DUTY_W'($urandom);
               3:       duty = DUTY_ONE - DUTY_W'(1);
               default: duty = DUTY_W'($urandom_range(0, 65536));
            endcase
            send_tone(freq, duty, calc_tone_timing(freq, duty, sys_clock_shadow));
         end
         drain_results();
      end

      repeat (RESULT_LATENCY + 16) @(posedge clock);
      if (pending_timing.size() != 0) begin
         $display("%0t ns: %0d results expected, none arrived", $time, pending_timing.size());
         mismatches++;
      end

      $display("Sent %0d tone requests over %0d clock register settings, %0d results checked.",
               tones_sent, clock_settings, results_seen);
      $display("Results: %0d new timing, %0d stops, %0d too-high flags, %0d mismatches.",
               timing_results, stop_results, high_results, mismatches);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
